### rtl/isut_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// isut_pkg
// Shared types and constants for the inode sector usage tally: item structs,
// mode type codes, configuration register indexes and internal widths.
// ============================================================================
package isut_pkg;

    // Number of direct block addresses held in an inode
    localparam int DIRECT_ADDRESSES_DEF = 10;

    // Width of a data block count (ceil of 2^32 / 512 fits in 24 bits)
    localparam int BLK_W = 24;
    // Width of a per-file sector count (block count times four, plus overhead)
    localparam int SEC_W = 26;

    // Mode type nibble codes
    localparam logic [3:0] KIND_FIFO = 4'd1;
    localparam logic [3:0] KIND_CHR  = 4'd2;
    localparam logic [3:0] KIND_DIR  = 4'd4;
    localparam logic [3:0] KIND_BLK  = 4'd6;
    localparam logic [3:0] KIND_REG  = 4'd8;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_OLD_SEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_SEL = 1'b1;
    localparam int CFG_DATA_W = 2;

    // Block size select codes
    localparam logic [1:0] BSEL_512  = 2'd0;
    localparam logic [1:0] BSEL_1024 = 2'd1;
    localparam logic [1:0] BSEL_2048 = 2'd2;

    // One input item
    typedef struct packed {
        logic        first_inode;
        logic [3:0]  file_kind;
        logic [31:0] file_size;
    } t_in_item;

    // One result item
    typedef struct packed {
        logic [31:0]        file_old_sectors;
        logic [31:0]        file_new_sectors;
        logic [31:0]        total_old_sectors;
        logic [31:0]        total_new_sectors;
        logic signed [31:0] total_extra_sectors;
        logic [15:0]        file_count;
    } t_out_item;

endpackage

### rtl/inode_sector_usage_tally.sv
`timescale 1ns / 1ps
// ============================================================================
// inode_sector_usage_tally
// Per-inode sector usage at an old and a new logical block size, with
// saturating running totals of old, new and extra sectors and of allocated
// inodes.
//
//   channel   direction  handshake                    payload
//   in        input      i_in_valid / o_in_ready      i_in_item  (t_in_item)
//   out       output     o_out_valid / i_out_ready    o_out_item (t_out_item)
//   cfg       input      i_cfg_we                     i_cfg_index, i_cfg_wdata
//
// One item per cycle sustained while the output is not stalled; an accepted
// item passes through the input register, then the result register, with the
// sector logic and the running totals between them, and o_out_valid rises
// when the item reaches the result register.
// Synchronous active-low reset clears totals and valid flags and returns the
// block selects to 512 bytes (old) and 1024 bytes (new).
// An output stall holds the result register; the input register drains into
// it as soon as it frees, so one item is taken while a result waits.
// ============================================================================
module inode_sector_usage_tally #(
    parameter int DIRECT_ADDRESSES = isut_pkg::DIRECT_ADDRESSES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  isut_pkg::t_in_item                i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output isut_pkg::t_out_item               o_out_item,
    input  logic                              i_cfg_we,
    input  logic [isut_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [isut_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    localparam int SW = isut_pkg::SEC_W;
    localparam logic signed [33:0] EXTRA_MAX = 34'sh0_7FFF_FFFF;
    localparam logic signed [33:0] EXTRA_MIN = -34'sh0_8000_0000;

    logic [1:0]          r_old_sel;
    logic [1:0]          r_new_sel;
    logic                r_a_valid;
    isut_pkg::t_in_item  r_a_item;
    logic                r_out_valid;
    isut_pkg::t_out_item r_out_item;
    logic [31:0]         r_old_sum;
    logic [31:0]         r_new_sum;
    logic signed [31:0]  r_extra_sum;
    logic [15:0]         r_count;

    logic [31:0]         n_old_sum;
    logic [31:0]         n_new_sum;
    logic signed [31:0]  n_extra_sum;
    logic [15:0]         n_count;

    logic                a_advance;
    logic                b_free;
    logic                is_data;
    logic                is_special;
    logic [SW-1:0]       old_raw;
    logic [SW-1:0]       new_raw;
    logic [SW-1:0]       fo;
    logic [SW-1:0]       fn;
    logic [31:0]         base_old;
    logic [31:0]         base_new;
    logic signed [31:0]  base_extra;
    logic [15:0]         base_count;
    logic [32:0]         old_add;
    logic [32:0]         new_add;
    logic signed [33:0]  extra_add;

    // Handshake: result register frees when empty or taken this cycle
    assign b_free      = !r_out_valid || i_out_ready;
    assign a_advance   = r_a_valid && b_free;
    assign o_in_ready  = !r_a_valid || b_free;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_old_sel <= isut_pkg::BSEL_512;
            r_new_sel <= isut_pkg::BSEL_1024;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                isut_pkg::CFG_OLD_SEL: r_old_sel <= i_cfg_wdata;
                isut_pkg::CFG_NEW_SEL: r_new_sel <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_a_item <= i_in_item;
        end
    end

    // Sector counts at both block sizes
    isut_sector_calc #(
        .DIRECT_ADDRESSES (DIRECT_ADDRESSES)
    ) u_old_calc (
        .i_size    (r_a_item.file_size),
        .i_bsel    (r_old_sel),
        .o_sectors (old_raw)
    );

    isut_sector_calc #(
        .DIRECT_ADDRESSES (DIRECT_ADDRESSES)
    ) u_new_calc (
        .i_size    (r_a_item.file_size),
        .i_bsel    (r_new_sel),
        .o_sectors (new_raw)
    );

    // Classify the inode and drop sectors for anything but directories and regular files
    always_comb begin
        is_data    = r_a_item.file_kind inside {isut_pkg::KIND_DIR, isut_pkg::KIND_REG};
        is_special = r_a_item.file_kind inside {isut_pkg::KIND_BLK, isut_pkg::KIND_CHR,
                                                isut_pkg::KIND_FIFO};
        fo = is_data ? old_raw : '0;
        fn = is_data ? new_raw : '0;
    end

    // Running totals: clear on first inode, then saturating adds
    always_comb begin
        base_old   = r_a_item.first_inode ? '0 : r_old_sum;
        base_new   = r_a_item.first_inode ? '0 : r_new_sum;
        base_extra = r_a_item.first_inode ? '0 : r_extra_sum;
        base_count = r_a_item.first_inode ? '0 : r_count;

        old_add   = {1'b0, base_old} + {{(33-SW){1'b0}}, fo};
        new_add   = {1'b0, base_new} + {{(33-SW){1'b0}}, fn};
        extra_add = 34'(base_extra) + signed'({{(34-SW){1'b0}}, fn})
                  - signed'({{(34-SW){1'b0}}, fo});

        n_old_sum = old_add[32] ? 32'hFFFF_FFFF : old_add[31:0];
        n_new_sum = new_add[32] ? 32'hFFFF_FFFF : new_add[31:0];
        if (extra_add > EXTRA_MAX) begin
            n_extra_sum = EXTRA_MAX[31:0];
        end else if (extra_add < EXTRA_MIN) begin
            n_extra_sum = EXTRA_MIN[31:0];
        end else begin
            n_extra_sum = extra_add[31:0];
        end
        if ((is_data || is_special) && (base_count != 16'hFFFF)) begin
            n_count = base_count + 16'd1;
        end else begin
            n_count = base_count;
        end
    end

    // Accumulators advance once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_old_sum   <= '0;
            r_new_sum   <= '0;
            r_extra_sum <= '0;
            r_count     <= '0;
        end else if (a_advance) begin
            r_old_sum   <= n_old_sum;
            r_new_sum   <= n_new_sum;
            r_extra_sum <= n_extra_sum;
            r_count     <= n_count;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_free) begin
            r_out_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_advance) begin
            r_out_item.file_old_sectors    <= {{(32-SW){1'b0}}, fo};
            r_out_item.file_new_sectors    <= {{(32-SW){1'b0}}, fn};
            r_out_item.total_old_sectors   <= n_old_sum;
            r_out_item.total_new_sectors   <= n_new_sum;
            r_out_item.total_extra_sectors <= n_extra_sum;
            r_out_item.file_count          <= n_count;
        end
    end

    // Reported totals track the accumulators
    a_totals_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_advance |=> (o_out_item.total_old_sectors == r_old_sum)
                   && (o_out_item.total_new_sectors == r_new_sum)
                   && (o_out_item.file_count == r_count))
        else $error("reported totals differ from accumulators");

    // Inodes other than directories and regular files contribute no sectors
    a_no_sectors: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_advance && !is_data) |=> (o_out_item.file_old_sectors == 32'd0)
                                 && (o_out_item.file_new_sectors == 32'd0))
        else $error("sectors reported for a non-file inode");

    // A first inode restarts the totals from its own sectors
    a_first_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_advance && r_a_item.first_inode) |=>
            (o_out_item.total_old_sectors == o_out_item.file_old_sectors)
         && (o_out_item.total_new_sectors == o_out_item.file_new_sectors))
        else $error("totals not cleared on first inode");

endmodule

### rtl/isut_sector_calc.sv
`timescale 1ns / 1ps
// ============================================================================
// isut_sector_calc
// Sectors occupied by one file at a given logical block size: data blocks
// plus single, double and triple indirect overhead blocks. Pure logic.
// ============================================================================
module isut_sector_calc #(
    parameter int DIRECT_ADDRESSES = isut_pkg::DIRECT_ADDRESSES_DEF
) (
    input  logic [31:0]                i_size,
    input  logic [1:0]                 i_bsel,
    output logic [isut_pkg::SEC_W-1:0] o_sectors
);

    localparam int BW = isut_pkg::BLK_W;

    logic [1:0]    k;
    logic [32:0]   size_up;
    logic [32:0]   blocks_w;
    logic [BW-1:0] blocks;
    logic [BW-1:0] d;
    logic [BW-1:0] ind;
    logic [BW-1:0] ind_sq;
    logic [BW-1:0] t1;
    logic [BW-1:0] t2;
    logic [BW-1:0] tot;
    logic [3:0]    blk_shift;
    logic [3:0]    ind_shift;

    // Map select code to log2 of sectors per block; an unused code means 2048
    always_comb begin
        case (i_bsel)
            isut_pkg::BSEL_512:  k = 2'd0;
            isut_pkg::BSEL_1024: k = 2'd1;
            default:             k = 2'd2;
        endcase
    end

    // Round the byte size up to whole blocks
    assign blk_shift = 4'd9 + {2'b00, k};
    assign ind_shift = 4'd7 + {2'b00, k};
    assign size_up   = {1'b0, i_size} + ((33'd512 << k) - 33'd1);
    assign blocks_w  = size_up >> blk_shift;
    assign blocks    = blocks_w[BW-1:0];

    // Addresses per indirect block and its square
    assign d      = BW'(DIRECT_ADDRESSES);
    assign ind    = BW'(128) << k;
    assign ind_sq = BW'(1) << ({3'b000, k} * 5'd2 + 5'd14);

    // Indirect overhead beyond the first single indirect block
    assign t1 = (blocks - d + ind - BW'(1)) >> ind_shift;
    assign t2 = t1 + ((t1 + ind - BW'(1)) >> ind_shift);

    // Select the tier the file falls into
    always_comb begin
        if (blocks <= d) begin
            tot = blocks;
        end else if (blocks <= d + ind) begin
            tot = blocks + BW'(1);
        end else if (blocks <= d + ind_sq) begin
            tot = blocks + BW'(1) + t1;
        end else begin
            tot = blocks + BW'(1) + t2;
        end
    end

    // Scale blocks to 512-byte sectors
    assign o_sectors = {2'b00, tot} << k;

endmodule
